>>> sv/tda_pkg.sv
package tda_pkg;

  localparam int unsigned ANGLE_ITERATIONS_DEF = 32;
  localparam int unsigned CNT_W = 6;

  localparam int unsigned LAT_W = 31;
  localparam int unsigned LON_W = 32;
  localparam int unsigned DIST_W = 31;
  localparam int unsigned TOTAL_W = 40;
  localparam int unsigned BAM_W = 32;
  localparam int unsigned NUM_W = 54;
  localparam int unsigned REM_W = 22;
  localparam int unsigned CX_W = 50;
  localparam int unsigned CZ_W = 34;
  localparam int unsigned RAD_W = 63;

  localparam logic signed [LAT_W-1:0] LAT_LIMIT = 31'sd900000000;
  localparam logic [REM_W:0] BAM_DIVISOR = 23'd3515625;
  localparam logic [NUM_W-1:0] BAM_ROUND = 54'd1757812;
  localparam logic signed [CX_W-1:0] CORDIC_GAIN = 50'sd2608131496;
  localparam logic [31:0] TURN_DIAM_LO = 32'd3711067422;
  localparam logic [RAD_W-1:0] ONE_Q62 = {1'b1, 62'd0};
  localparam int unsigned DIV_STEPS = NUM_W;
  localparam int unsigned SQRT_STEPS = 32;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_ROT,
    ST_RPOST,
    ST_MUL,
    ST_SQRT,
    ST_ATAN,
    ST_DMUL,
    ST_DIST,
    ST_FIN
  } state_e;

  function automatic logic [30:0] atan_tab(input logic [CNT_W-1:0] idx);
    logic [30:0] r;
    unique case (idx)
      6'd0:  r = 31'd1073741824;
      6'd1:  r = 31'd633866811;
      6'd2:  r = 31'd334917815;
      6'd3:  r = 31'd170009512;
      6'd4:  r = 31'd85334662;
      6'd5:  r = 31'd42708931;
      6'd6:  r = 31'd21359677;
      6'd7:  r = 31'd10680490;
      6'd8:  r = 31'd5340327;
      6'd9:  r = 31'd2670173;
      6'd10: r = 31'd1335088;
      6'd11: r = 31'd667544;
      6'd12: r = 31'd333772;
      6'd13: r = 31'd166886;
      6'd14: r = 31'd83443;
      6'd15: r = 31'd41722;
      6'd16: r = 31'd20861;
      6'd17: r = 31'd10430;
      6'd18: r = 31'd5215;
      6'd19: r = 31'd2608;
      6'd20: r = 31'd1304;
      6'd21: r = 31'd652;
      6'd22: r = 31'd326;
      6'd23: r = 31'd163;
      6'd24: r = 31'd81;
      6'd25: r = 31'd41;
      6'd26: r = 31'd20;
      6'd27: r = 31'd10;
      6'd28: r = 31'd5;
      6'd29: r = 31'd3;
      6'd30: r = 31'd1;
      6'd31: r = 31'd1;
      default: r = 31'd0;
    endcase
    return r;
  endfunction

endpackage

>>> sv/track_distance_accumulator.sv
// Haversine track distance: one result per input point, one point in flight at a time.
// A point is converted to binary angles by a bit-serial divider (latitude, then
// longitude), then a shared CORDIC runs four rotations and one vectoring pass of
// ANGLE_ITERATIONS iterations each (plus a post step after each rotation), a shared
// 32x32 multiplier forms the products and a shared bitwise square root runs twice.
// First points and segment starts skip the CORDIC, multiplier and square root. Input
// is taken again once the result is in the output register; start_distance_cm is
// read by the first point.
module track_distance_accumulator
  import tda_pkg::*;
#(
  parameter int unsigned ANGLE_ITERATIONS = ANGLE_ITERATIONS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [39:0]  cfg_data_i,      // start_distance_cm
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [63:0]  s_axis_tdata_i,  // latitude[30:0], longitude[62:31], zero
  input  logic         s_axis_tuser_i,  // segment_start
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [71:0]  m_axis_tdata_o,  // step_distance_cm[30:0], total_distance_cm[70:31], zero
  output logic         m_axis_tuser_o   // total_saturated
);

  localparam logic [CNT_W-1:0] ITER_LAST = CNT_W'(ANGLE_ITERATIONS - 1);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);
  localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(SQRT_STEPS - 1);
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  function automatic logic [31:0] to_q31(input logic signed [CX_W-1:0] v);
    logic [CX_W-1:0] m;
    logic [CX_W-1:0] h;
    m = v[CX_W-1] ? CX_W'(-v) : CX_W'(v);
    h = (m + CX_W'(1)) >> 1;
    return (h > CX_W'(33'h080000000)) ? 32'h80000000 : h[31:0];
  endfunction

  function automatic logic [31:0] rnd31(input logic [63:0] p);
    logic [63:0] t;
    t = p + 64'h40000000;
    return t[62:31];
  endfunction

  state_e state_q, state_d;

  logic [TOTAL_W-1:0] start_q, total_q;
  logic               have_point_q;
  logic [BAM_W-1:0]   prev_lat_b_q, prev_lon_b_q, lat_b_q, lon_b_q;
  logic signed [LAT_W-1:0] lat_c;
  logic signed [LON_W-1:0] lon_q;
  logic               seg_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [1:0]         run_q;

  logic [NUM_W-1:0]   div_num_q;
  logic [REM_W-1:0]   div_rem_q;
  logic [BAM_W-1:0]   div_quo_q;
  logic               div_neg_q;
  logic [REM_W:0]     rem_sh;
  logic               div_ge;
  logic [BAM_W-1:0]   quo_n, bam_n;
  logic [31:0]        lon_mag;

  logic signed [CX_W-1:0] cx_q, cy_q, xs, ys, cx_n, cy_n;
  logic signed [CZ_W-1:0] cz_q, cz_n, at;
  logic                   sigma, vec_mode;

  logic [31:0] sl_q, so_q, c1_q, c2_q, v_q, s_q, theta;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod_q, acc_q;
  logic [64:0] a_sum;
  logic [RAD_W-1:0] a_q, a_n, sq_a_q, sq_r_q, sq_bit_q, sq_t, sq_a_n, sq_r_n;
  logic        sq_ge;
  logic [65:0] dist_sum;
  logic [DIST_W-1:0] dist_q;
  logic [TOTAL_W:0]  total_sum;
  logic [TOTAL_W-1:0] total_n;

  logic                out_valid_q;
  logic [DIST_W-1:0]   out_dist_q;
  logic [TOTAL_W-1:0]  out_total_q;

  assign cfg_ready_o = 1'b1;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o = {1'b0, out_total_q, out_dist_q};
  assign m_axis_tuser_o = (out_total_q == TOTAL_MAX);

  // latitude clamp
  always_comb begin
    lat_c = signed'(s_axis_tdata_i[30:0]);
    if (lat_c > LAT_LIMIT) begin
      lat_c = LAT_LIMIT;
    end else if (lat_c < -LAT_LIMIT) begin
      lat_c = -LAT_LIMIT;
    end
  end

  // bit-serial divider step
  assign rem_sh = {div_rem_q, div_num_q[NUM_W-1]};
  assign div_ge = (rem_sh >= BAM_DIVISOR);
  assign quo_n = {div_quo_q[BAM_W-2:0], div_ge};
  assign bam_n = div_neg_q ? BAM_W'(-quo_n) : quo_n;
  assign lon_mag = lon_q[LON_W-1] ? 32'(-lon_q) : 32'(lon_q);

  // cordic micro-rotation
  assign vec_mode = (state_q == ST_ATAN);
  assign xs = cx_q >>> cnt_q;
  assign ys = cy_q >>> cnt_q;
  assign at = CZ_W'(atan_tab(cnt_q));
  assign sigma = vec_mode ? cy_q[CX_W-1] : ~cz_q[CZ_W-1];
  assign cx_n = sigma ? cx_q - ys : cx_q + ys;
  assign cy_n = sigma ? cy_q + xs : cy_q - xs;
  assign cz_n = sigma ? cz_q - at : cz_q + at;

  // shared multiplier operands
  always_comb begin
    mul_a = c1_q;
    mul_b = c2_q;
    if (state_q == ST_DMUL) begin
      mul_a = theta;
      mul_b = TURN_DIAM_LO;
    end else begin
      unique case (cnt_q[2:0])
        3'd1: begin
          mul_a = rnd31(prod_q);
          mul_b = so_q;
        end
        3'd2: begin
          mul_a = sl_q;
          mul_b = sl_q;
        end
        3'd3: begin
          mul_a = v_q;
          mul_b = so_q;
        end
        default: begin
          mul_a = c1_q;
          mul_b = c2_q;
        end
      endcase
    end
  end

  assign a_sum = {1'b0, acc_q} + {1'b0, prod_q};
  assign a_n = (a_sum > 65'(ONE_Q62)) ? ONE_Q62 : a_sum[RAD_W-1:0];

  // bitwise square root step
  assign sq_t = sq_r_q + sq_bit_q;
  assign sq_ge = (sq_a_q >= sq_t);
  assign sq_a_n = sq_ge ? sq_a_q - sq_t : sq_a_q;
  assign sq_r_n = sq_ge ? (sq_r_q >> 1) + sq_bit_q : sq_r_q >> 1;

  always_comb begin
    if (cz_q[CZ_W-1]) begin
      theta = '0;
    end else if (cz_q > CZ_W'(33'h080000000)) begin
      theta = 32'h80000000;
    end else begin
      theta = cz_q[31:0];
    end
  end

  assign dist_sum = {2'b0, theta, 32'd0} + {2'b0, prod_q} + 66'h100000000;
  assign total_sum = {1'b0, total_q} + (TOTAL_W + 1)'(dist_q);
  assign total_n = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (cnt_q == DIV_LAST && run_q[0]) begin
          state_d = (!have_point_q || seg_q) ? ST_FIN : ST_ROT;
        end
      end
      ST_ROT: begin
        if (cnt_q == ITER_LAST) begin
          state_d = ST_RPOST;
        end
      end
      ST_RPOST: state_d = (run_q == 2'd3) ? ST_MUL : ST_ROT;
      ST_MUL: begin
        if (cnt_q == CNT_W'(4)) begin
          state_d = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (cnt_q == SQRT_LAST && run_q[0]) begin
          state_d = ST_ATAN;
        end
      end
      ST_ATAN: begin
        if (cnt_q == ITER_LAST) begin
          state_d = ST_DMUL;
        end
      end
      ST_DMUL: state_d = ST_DIST;
      ST_DIST: state_d = ST_FIN;
      ST_FIN: begin
        if (!out_valid_q || m_axis_tready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // control and persistent state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      total_q <= '0;
      have_point_q <= 1'b0;
      prev_lat_b_q <= '0;
      prev_lon_b_q <= '0;
      cnt_q <= '0;
      run_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        start_q <= cfg_data_i;
      end
      if (out_valid_q && m_axis_tready_i && state_q != ST_FIN) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          cnt_q <= '0;
          run_q <= '0;
        end
        ST_DIV, ST_SQRT: begin
          if (cnt_q == ((state_q == ST_DIV) ? DIV_LAST : SQRT_LAST)) begin
            cnt_q <= '0;
            run_q <= run_q[0] ? 2'd0 : 2'd1;
          end else begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end
        ST_ROT, ST_ATAN: begin
          cnt_q <= (cnt_q == ITER_LAST) ? '0 : cnt_q + CNT_W'(1);
        end
        ST_RPOST: begin
          cnt_q <= '0;
          run_q <= run_q + 2'd1;
        end
        ST_MUL: begin
          cnt_q <= (cnt_q == CNT_W'(4)) ? '0 : cnt_q + CNT_W'(1);
        end
        ST_FIN: begin
          if (!out_valid_q || m_axis_tready_i) begin
            out_valid_q <= 1'b1;
            have_point_q <= 1'b1;
            prev_lat_b_q <= lat_b_q;
            prev_lon_b_q <= lon_b_q;
            if (!have_point_q) begin
              total_q <= start_q;
            end else if (!seg_q) begin
              total_q <= total_n;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        lon_q <= signed'(s_axis_tdata_i[62:31]);
        seg_q <= s_axis_tuser_i;
        div_num_q <= {32'(lat_c[LAT_W-1] ? -lat_c : lat_c), 22'd0} + BAM_ROUND;
        div_neg_q <= lat_c[LAT_W-1];
        div_rem_q <= '0;
        div_quo_q <= '0;
        dist_q <= '0;
      end
      ST_DIV: begin
        if (cnt_q == DIV_LAST && !run_q[0]) begin
          lat_b_q <= bam_n;
          div_num_q <= {lon_mag, 22'd0} + BAM_ROUND;
          div_neg_q <= lon_q[LON_W-1];
          div_rem_q <= '0;
          div_quo_q <= '0;
          cx_q <= CORDIC_GAIN;
          cy_q <= '0;
          cz_q <= CZ_W'(signed'(bam_n - prev_lat_b_q));
        end else begin
          div_num_q <= {div_num_q[NUM_W-2:0], 1'b0};
          div_rem_q <= div_ge ? REM_W'(rem_sh - BAM_DIVISOR) : rem_sh[REM_W-1:0];
          div_quo_q <= quo_n;
          if (cnt_q == DIV_LAST) begin
            lon_b_q <= bam_n;
          end
        end
      end
      ST_ROT, ST_ATAN: begin
        cx_q <= cx_n;
        cy_q <= cy_n;
        cz_q <= cz_n;
      end
      ST_RPOST: begin
        unique case (run_q)
          2'd0: sl_q <= to_q31(cy_q);
          2'd1: so_q <= to_q31(cy_q);
          2'd2: c1_q <= cx_q[CX_W-1] ? 32'd0 : to_q31(cx_q);
          default: c2_q <= cx_q[CX_W-1] ? 32'd0 : to_q31(cx_q);
        endcase
        unique case (run_q)
          2'd0: cz_q <= CZ_W'(signed'(lon_b_q - prev_lon_b_q));
          2'd1: cz_q <= CZ_W'(signed'(prev_lat_b_q)) <<< 1;
          default: cz_q <= CZ_W'(signed'(lat_b_q)) <<< 1;
        endcase
        cx_q <= CORDIC_GAIN;
        cy_q <= '0;
      end
      ST_MUL: begin
        prod_q <= mul_a * mul_b;
        if (cnt_q == CNT_W'(2)) begin
          v_q <= rnd31(prod_q);
        end
        if (cnt_q == CNT_W'(3)) begin
          acc_q <= prod_q;
        end
        if (cnt_q == CNT_W'(4)) begin
          a_q <= a_n;
          sq_a_q <= a_n;
          sq_r_q <= '0;
          sq_bit_q <= ONE_Q62;
        end
      end
      ST_SQRT: begin
        if (cnt_q == SQRT_LAST && !run_q[0]) begin
          s_q <= sq_r_n[31:0];
          sq_a_q <= ONE_Q62 - a_q;
          sq_r_q <= '0;
          sq_bit_q <= ONE_Q62;
        end else begin
          sq_a_q <= sq_a_n;
          sq_r_q <= sq_r_n;
          sq_bit_q <= sq_bit_q >> 2;
          if (cnt_q == SQRT_LAST) begin
            cx_q <= CX_W'({sq_r_n[31:0], 16'd0});
            cy_q <= CX_W'({s_q, 16'd0});
            cz_q <= '0;
          end
        end
      end
      ST_DMUL: begin
        prod_q <= mul_a * mul_b;
      end
      ST_DIST: begin
        dist_q <= dist_sum[DIST_W+32:33];
      end
      ST_FIN: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_dist_q <= dist_q;
          out_total_q <= !have_point_q ? start_q : (seg_q ? total_q : total_n);
        end
      end
      default: begin
      end
    endcase
  end

endmodule
